@@ rtl/car_pkg.sv @@
`default_nettype none

package car_pkg;

  // default configuration of the receive window
  localparam int unsigned Window  = 64;
  localparam int unsigned SeqBits = 16;

  // field widths
  localparam int unsigned NumW    = 16;
  localparam int unsigned StatusW = 2;

  // register file: one register, byte addressed, word aligned
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;
  localparam int unsigned RegTotalIdx = 0;
  localparam logic [NumW-1:0] TotalReset = 16'd20000;

  typedef enum logic [1:0] {
    StatusNew = 2'd0,
    StatusDup = 2'd1,
    StatusIgn = 2'd2
  } car_status_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSlot,
    StLook,
    StWalk,
    StResp
  } car_state_e;

endpackage

`default_nettype wire

@@ rtl/car_ram.sv @@
`default_nettype none

module car_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/cumulative_ack_receiver_top.sv @@
`default_nettype none

// Cumulative-ack receive window. Each input word carries one received
// sequence number; each produces exactly one result word with the new
// next-expected number (cum_ack), a status (new, duplicate, or ignored when
// out of window or at/above total_messages) and a flag once every message
// has arrived. The receive bitmap lives in a 1-bit wide RAM of WINDOW
// entries with a registered read; after reset a clearing pass writes every
// entry to zero, one per cycle, and no word is taken until it is done
// (configuration writes are taken at any time). An ignored or below-pointer
// number goes straight to its result; any other first has its entry read. A
// number that hits an already marked entry is a duplicate; a newly accepted
// one that lands ahead of the pointer is marked, and one that lands on the
// pointer moves it on, after which the walk reads and clears one RAM entry
// per cycle for each marked entry the pointer passes (at most WINDOW-1). A
// finished result waits while the previous one is still held in the output
// register; one word is processed at a time.

module cumulative_ack_receiver_top #(
  parameter int unsigned WINDOW   = car_pkg::Window,
  parameter int unsigned SEQ_BITS = car_pkg::SeqBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input words
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [car_pkg::NumW-1:0]     seq_num_i,
  // result words
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [car_pkg::NumW-1:0]     cum_ack_o,
  output logic      [car_pkg::StatusW-1:0]  status_o,
  output logic                              all_received_o,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [car_pkg::PaddrW-1:0]   paddr,
  input  wire logic [car_pkg::PdataW-1:0]   pwdata,
  output logic      [car_pkg::PdataW-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned NumW   = car_pkg::NumW;
  localparam int unsigned IdxW   = $clog2(WINDOW);
  localparam int unsigned StepsW = $clog2(WINDOW + 1);
  localparam int unsigned SeqW   = (SEQ_BITS < NumW) ? SEQ_BITS : NumW;
  localparam logic [NumW-1:0] SeqMask = NumW'((33'd1 << SeqW) - 33'd1);

  car_pkg::car_state_e state_q, state_d;

  logic [NumW-1:0]    ne_q, ne_d;           // next expected sequence number
  logic [IdxW-1:0]    ne_slot_q, ne_slot_d; // ne_q modulo WINDOW
  logic [NumW-1:0]    total_q;
  logic [IdxW-1:0]    clr_q, clr_d;
  logic [IdxW-1:0]    off_q, off_d;         // seq - ne, inside the window
  logic               off_zero_q, off_zero_d;
  logic [IdxW-1:0]    seq_slot_q, seq_slot_d;
  logic [StepsW-1:0]  steps_q, steps_d;
  car_pkg::car_status_e status_q, status_d;

  logic                        out_valid_q, out_valid_d;
  logic [NumW-1:0]             cum_ack_q, cum_ack_d;
  car_pkg::car_status_e        out_status_q, out_status_d;
  logic                        all_q, all_d;

  // bitmap RAM ports
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [0:0]      ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [0:0]      ram_rdata;

  car_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // register port: one register, total_messages
  logic cfg_we;
  logic reg_hit;

  assign reg_hit = (paddr[2] == 1'(car_pkg::RegTotalIdx));
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(car_pkg::PdataW-NumW){1'b0}}, total_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= car_pkg::TotalReset;
    end else if (cfg_we) begin
      total_q <= pwdata[NumW-1:0];
    end
  end

  // classification of an arriving word against the window
  logic [NumW-1:0] seq_in;
  logic [NumW:0]   diff;
  logic            below_ptr;
  logic            beyond_win;
  logic            ignore_in;

  assign seq_in     = seq_num_i & SeqMask;
  assign diff       = {1'b0, seq_in} - {1'b0, ne_q};
  assign below_ptr  = diff[NumW];
  assign beyond_win = !below_ptr && (diff[NumW-1:0] >= NumW'(WINDOW));
  assign ignore_in  = (seq_in >= total_q) || beyond_win;

  // ring slot arithmetic
  logic [IdxW-1:0] ne_slot_inc;
  logic [IdxW:0]   slot_sum;
  logic [IdxW:0]   slot_wrap;
  logic            walk_go;

  assign ne_slot_inc = (ne_slot_q == IdxW'(WINDOW - 1)) ? '0 : ne_slot_q + 1'b1;
  assign slot_sum    = {1'b0, ne_slot_q} + {1'b0, off_q};
  assign slot_wrap   = (slot_sum >= (IdxW+1)'(WINDOW)) ?
                       slot_sum - (IdxW+1)'(WINDOW) : slot_sum;
  // pointer passes a marked entry while below the total
  assign walk_go     = (steps_q != StepsW'(WINDOW)) && (ne_q < total_q) && ram_rdata[0];

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == car_pkg::StIdle);

  always_comb begin
    state_d      = state_q;
    ne_d         = ne_q;
    ne_slot_d    = ne_slot_q;
    clr_d        = clr_q;
    off_d        = off_q;
    off_zero_d   = off_zero_q;
    seq_slot_d   = seq_slot_q;
    steps_d      = steps_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cum_ack_d    = cum_ack_q;
    out_status_d = out_status_q;
    all_d        = all_q;
    ram_we       = 1'b0;
    ram_waddr    = ne_slot_q;
    ram_wdata    = 1'b0;
    ram_raddr    = ne_slot_q;

    case (state_q)
      car_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IdxW'(WINDOW - 1)) begin
          state_d = car_pkg::StIdle;
        end
      end

      car_pkg::StIdle: begin
        if (in_valid_i) begin
          off_d      = diff[IdxW-1:0];
          off_zero_d = (diff[NumW-1:0] == '0);
          if (ignore_in) begin
            status_d = car_pkg::StatusIgn;
            state_d  = car_pkg::StResp;
          end else if (below_ptr) begin
            status_d = car_pkg::StatusDup;
            state_d  = car_pkg::StResp;
          end else begin
            state_d = car_pkg::StSlot;
          end
        end
      end

      car_pkg::StSlot: begin
        // look up the entry of the arriving number
        ram_raddr  = slot_wrap[IdxW-1:0];
        seq_slot_d = slot_wrap[IdxW-1:0];
        state_d    = car_pkg::StLook;
      end

      car_pkg::StLook: begin
        if (ram_rdata[0]) begin
          status_d = car_pkg::StatusDup;
          state_d  = car_pkg::StResp;
        end else if (off_zero_q) begin
          // number equals the pointer: mark and clear in one go
          ne_d      = ne_q + 1'b1;
          ne_slot_d = ne_slot_inc;
          steps_d   = StepsW'(1);
          ram_raddr = ne_slot_inc;
          state_d   = car_pkg::StWalk;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = seq_slot_q;
          ram_wdata = 1'b1;
          ram_raddr = ne_slot_q;
          steps_d   = '0;
          state_d   = car_pkg::StWalk;
        end
      end

      car_pkg::StWalk: begin
        // read data is the entry at the pointer
        if (walk_go) begin
          ram_we    = 1'b1;
          ram_waddr = ne_slot_q;
          ram_wdata = 1'b0;
          ram_raddr = ne_slot_inc;
          ne_d      = ne_q + 1'b1;
          ne_slot_d = ne_slot_inc;
          steps_d   = steps_q + 1'b1;
        end else begin
          status_d = car_pkg::StatusNew;
          state_d  = car_pkg::StResp;
        end
      end

      car_pkg::StResp: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          cum_ack_d    = ne_q;
          out_status_d = status_q;
          all_d        = (ne_q >= total_q);
          state_d      = car_pkg::StIdle;
        end
      end

      default: begin
        state_d = car_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= car_pkg::StClear;
      ne_q        <= '0;
      ne_slot_q   <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ne_q        <= ne_d;
      ne_slot_q   <= ne_slot_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    off_zero_q   <= off_zero_d;
    seq_slot_q   <= seq_slot_d;
    steps_q      <= steps_d;
    status_q     <= status_d;
    cum_ack_q    <= cum_ack_d;
    out_status_q <= out_status_d;
    all_q        <= all_d;
  end

  assign out_valid_o    = out_valid_q;
  assign cum_ack_o      = cum_ack_q;
  assign status_o       = out_status_q;
  assign all_received_o = all_q;

  // pointer moves only while an entry is being marked or walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != car_pkg::StLook && state_q != car_pkg::StWalk) |=> $stable(ne_q))
    else $error("pointer moved outside of the walk");

  // pointer and its ring slot advance together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ne_q != $past(ne_q)) |-> (ne_slot_q != $past(ne_slot_q)))
    else $error("ring slot out of step with pointer");

  // the walk never passes more entries than the window holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == car_pkg::StWalk) |-> (steps_q <= StepsW'(WINDOW)))
    else $error("walk overran the window");

  // the bitmap is written only while clearing, marking or walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == car_pkg::StClear || state_q == car_pkg::StLook ||
                state_q == car_pkg::StWalk))
    else $error("bitmap written in a wrong state");

  // a result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(cum_ack_q) && $stable(out_status_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
